// File: hw/rtl/omp_pkg.sv
// ----------------------------------------------------------------------------
// omp_pkg
// Shared types, constants and helper functions for the opt-out marker
// payload checker.
// ----------------------------------------------------------------------------
package omp_pkg;

  // Default number of markers in one set
  localparam int unsigned MarkersDef = 8;

  // Fixed field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned NumW    = 3;
  localparam int unsigned LenW    = 3;
  localparam int unsigned InUserW = 3;
  localparam int unsigned OutDatW = 8;

  // Length saturates here; anything above four is neither two nor four
  localparam logic [LenW-1:0] LenSat = 3'd5;
  localparam logic [LenW-1:0] LenTwo = 3'd2;
  localparam logic [LenW-1:0] LenFour = 3'd4;

  // Character constants
  localparam logic [ByteW-1:0] ChPrintLo = 8'h20;
  localparam logic [ByteW-1:0] ChPrintHi = 8'h7E;
  localparam logic [ByteW-1:0] ChUpperA  = 8'h41;
  localparam logic [ByteW-1:0] ChUpperZ  = 8'h5A;
  localparam logic [ByteW-1:0] ChCaseOff = 8'h20;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChA       = 8'h61;
  localparam logic [ByteW-1:0] ChE       = 8'h65;
  localparam logic [ByteW-1:0] ChF       = 8'h66;
  localparam logic [ByteW-1:0] ChL       = 8'h6C;
  localparam logic [ByteW-1:0] ChN       = 8'h6E;
  localparam logic [ByteW-1:0] ChO       = 8'h6F;
  localparam logic [ByteW-1:0] ChS       = 8'h73;

  // Word recognizer for "0", "false" and "no"
  typedef enum logic [9:0] {
    WM_START = 10'b00_0000_0001,
    WM_ZERO  = 10'b00_0000_0010,
    WM_F     = 10'b00_0000_0100,
    WM_FA    = 10'b00_0000_1000,
    WM_FAL   = 10'b00_0001_0000,
    WM_FALS  = 10'b00_0010_0000,
    WM_FALSE = 10'b00_0100_0000,
    WM_N     = 10'b00_1000_0000,
    WM_NO    = 10'b01_0000_0000,
    WM_DEAD  = 10'b10_0000_0000
  } omp_wm_e;

  // One input transaction
  typedef struct packed {
    logic             present;
    logic             has_byte;
    logic [ByteW-1:0] data;
    logic             end_pay;
    logic             end_set;
  } omp_item_t;

  // One result transaction
  typedef struct packed {
    logic [NumW-1:0] number;
    logic            is_false;
    logic            excludes;
    logic            skip;
    logic            done;
  } omp_res_t;

  // Lower-case A..Z, pass everything else
  function automatic logic [ByteW-1:0] fold_case(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (b >= ChUpperA && b <= ChUpperZ) begin
      r = b + ChCaseOff;
    end
    return r;
  endfunction

  // Advance the word recognizer by one folded character
  function automatic omp_wm_e next_word(input omp_wm_e s, input logic [ByteW-1:0] ch);
    omp_wm_e n;
    n = WM_DEAD;
    case (s)
      WM_START: begin
        if (ch == ChZero) n = WM_ZERO;
        else if (ch == ChF) n = WM_F;
        else if (ch == ChN) n = WM_N;
      end
      WM_F:    n = (ch == ChA) ? WM_FA    : WM_DEAD;
      WM_FA:   n = (ch == ChL) ? WM_FAL   : WM_DEAD;
      WM_FAL:  n = (ch == ChS) ? WM_FALS  : WM_DEAD;
      WM_FALS: n = (ch == ChE) ? WM_FALSE : WM_DEAD;
      WM_N:    n = (ch == ChO) ? WM_NO    : WM_DEAD;
      default: n = WM_DEAD;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/omp_in_stage.sv
// ----------------------------------------------------------------------------
// omp_in_stage
// Input register: holds one accepted transaction until the evaluator takes it.
// ----------------------------------------------------------------------------
module omp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  omp_pkg::omp_item_t item_i,
  input  logic               take_i,
  output logic               valid_o,
  output omp_pkg::omp_item_t item_o
);
  import omp_pkg::*;

  logic      vld_q, vld_d;
  omp_item_t item_q;
  logic      load;

  // Room when empty or when the held item leaves this cycle
  assign ready_o = !vld_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/omp_eval.sv
// ----------------------------------------------------------------------------
// omp_eval
// Payload state, rule mask and the per-item decision logic.
// ----------------------------------------------------------------------------
module omp_eval #(
  parameter int unsigned Markers = omp_pkg::MarkersDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [omp_pkg::MaskW-1:0]  cfg_wdata_i,
  input  logic                       item_vld_i,
  input  omp_pkg::omp_item_t         item_i,
  input  logic                       out_free_i,
  output logic                       take_o,
  output logic                       res_vld_o,
  output omp_pkg::omp_res_t          res_o
);
  import omp_pkg::*;

  localparam int unsigned CntW = (Markers > 1) ? $clog2(Markers) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(Markers - 1);

  logic [Markers-1:0] mask_q;
  logic               nz_q, nz_d;
  logic               unp_q, unp_d;
  omp_wm_e            wm_q, wm_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               skip_q, skip_d;

  // Values after the current byte is absorbed
  logic               nz_b, unp_b;
  omp_wm_e            wm_b;
  logic [LenW-1:0]    len_b;
  logic               close, text_false, zero_false, is_false, excl, skip_nx;

  always_comb begin
    nz_b  = nz_q;
    unp_b = unp_q;
    wm_b  = wm_q;
    len_b = len_q;
    if (item_i.has_byte) begin
      if (len_q != LenSat) len_b = len_q + 1'b1;
      if (item_i.data != '0) begin
        nz_b = 1'b1;
        if (item_i.data < ChPrintLo || item_i.data > ChPrintHi) begin
          unp_b = 1'b1;
        end else begin
          wm_b = next_word(wm_q, fold_case(item_i.data));
        end
      end
    end
  end

  // Judge the closed payload
  assign close      = item_i.end_pay || item_i.end_set;
  assign text_false = nz_b && !unp_b &&
                      (wm_b == WM_ZERO || wm_b == WM_FALSE || wm_b == WM_NO);
  assign zero_false = !nz_b && (len_b == LenTwo || len_b == LenFour);
  assign is_false   = text_false || zero_false;
  assign excl       = item_i.present && (mask_q[cnt_q] || is_false);
  assign skip_nx    = skip_q || excl;

  // An item without a close needs no output slot
  assign take_o    = item_vld_i && (!close || out_free_i);
  assign res_vld_o = take_o && close;

  always_comb begin
    res_o          = '0;
    res_o.number   = NumW'(cnt_q);
    res_o.is_false = is_false;
    res_o.excludes = excl;
    res_o.skip     = skip_nx;
    res_o.done     = item_i.end_set;
  end

  // Next state
  always_comb begin
    nz_d   = nz_q;
    unp_d  = unp_q;
    wm_d   = wm_q;
    len_d  = len_q;
    cnt_d  = cnt_q;
    skip_d = skip_q;
    if (take_o) begin
      if (close) begin
        nz_d  = 1'b0;
        unp_d = 1'b0;
        wm_d  = WM_START;
        len_d = '0;
        if (item_i.end_set) begin
          cnt_d  = '0;
          skip_d = 1'b0;
        end else begin
          skip_d = skip_nx;
          if (cnt_q != CntLast) cnt_d = cnt_q + 1'b1;
        end
      end else begin
        nz_d  = nz_b;
        unp_d = unp_b;
        wm_d  = wm_b;
        len_d = len_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      nz_q   <= 1'b0;
      unp_q  <= 1'b0;
      wm_q   <= WM_START;
      len_q  <= '0;
      cnt_q  <= '0;
      skip_q <= 1'b0;
    end else begin
      if (cfg_we_i) mask_q <= cfg_wdata_i[Markers-1:0];
      nz_q   <= nz_d;
      unp_q  <= unp_d;
      wm_q   <= wm_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
    end
  end

endmodule

// File: hw/rtl/omp_out_stage.sv
// ----------------------------------------------------------------------------
// omp_out_stage
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
module omp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  omp_pkg::omp_res_t res_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output omp_pkg::omp_res_t res_o
);
  import omp_pkg::*;

  logic     vld_q, vld_d;
  omp_res_t res_q;

  // Slot frees up in the same cycle the receiver takes it
  assign free_o = !vld_q || ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

// File: hw/rtl/optout_marker_payload_checker_top.sv
// ----------------------------------------------------------------------------
// optout_marker_payload_checker_top
// Streams marker payload bytes and reports, per marker, whether it excludes
// a capture, with a running skip decision over the marker set.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one payload byte per transaction. tlast closes the
//   current marker; tuser flags presence, byte validity and the last marker.
//   A closing transaction yields one result transaction on the master stream;
//   other transactions only update the payload state.
//   cfg_we_i writes the per-marker rule mask (1 = presence alone excludes).
// Path: a closing transaction is held in the input register and then judged
//   into the result register, which presents its result; a full result
//   register can keep it waiting in the input register.
// Throughput: one transaction per cycle while the slave side is not stalled;
//   the payload state is one small recognizer and a few flags, updated in a single pass each cycle.
// Stall: while the result register is full and tready is low, a held closing
//   transaction waits in the input register and tready on the slave side
//   drops; non-closing bytes keep moving until a closing one is held.
// Reset: clears the mask, payload state, marker counter and skip flag, and
//   empties both registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
module optout_marker_payload_checker_top #(
  parameter int unsigned MARKERS = omp_pkg::MarkersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [omp_pkg::MaskW-1:0]     cfg_wdata_i,
  // Slave stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] payload_byte
  input  logic [omp_pkg::ByteW-1:0]     s_axis_tdata_i,
  // [0] marker_present, [1] has_byte, [2] end_of_markers
  input  logic [omp_pkg::InUserW-1:0]   s_axis_tuser_i,
  // end_of_payload
  input  logic                          s_axis_tlast_i,
  // Master stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [2:0] marker_number, [3] payload_is_false, [4] marker_excludes,
  // [5] skip_capture, [7:6] zero
  output logic [omp_pkg::OutDatW-1:0]   m_axis_tdata_o,
  // set_done
  output logic                          m_axis_tlast_o
);
  import omp_pkg::*;

  omp_item_t item_in, item_held;
  omp_res_t  res_nx, res_out;
  logic      in_vld, take, res_vld, out_free;

  // Unpack slave transaction
  always_comb begin
    item_in          = '0;
    item_in.present  = s_axis_tuser_i[0];
    item_in.has_byte = s_axis_tuser_i[1];
    item_in.end_set  = s_axis_tuser_i[2];
    item_in.data     = s_axis_tdata_i;
    item_in.end_pay  = s_axis_tlast_i;
  end

  omp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (item_in),
    .take_i  (take),
    .valid_o (in_vld),
    .item_o  (item_held)
  );

  omp_eval #(
    .Markers (MARKERS)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_vld_i  (in_vld),
    .item_i      (item_held),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_vld_o   (res_vld),
    .res_o       (res_nx)
  );

  omp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_vld),
    .res_i   (res_nx),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res_out)
  );

  // Pack master transaction
  assign m_axis_tdata_o = {2'b00, res_out.skip, res_out.excludes,
                           res_out.is_false, res_out.number};
  assign m_axis_tlast_o = res_out.done;

  // Assertions
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[2:0]) <= MARKERS - 1))
    else $error("marker number beyond marker count");

  a_excl_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |-> m_axis_tdata_o[5])
    else $error("excluding marker without skip");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_vld && !out_free)
    else $error("slave stalled without a blocked held item");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |=> m_axis_tvalid_o)
    else $error("result lost on load");

endmodule
